// File: src/csn_pkg.sv
// ----------------------------------------------------------------------------
// csn_pkg
// shared types and character constants for the c source normalizer
// ----------------------------------------------------------------------------
package csn_pkg;

  typedef enum logic [2:0] {
    MODE_CODE       = 3'd0,
    MODE_BLOCK      = 3'd1,
    MODE_BLOCK_STAR = 3'd2,
    MODE_LINE       = 3'd3,
    MODE_SQ         = 3'd4,
    MODE_SQ_ESC     = 3'd5,
    MODE_DQ         = 3'd6,
    MODE_DQ_ESC     = 3'd7
  } csn_mode_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // one result beat
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eos;
  } csn_res_t;

  // all results of one source byte, slot 0 goes out first
  typedef struct packed {
    logic [1:0]          cnt;
    csn_res_t [2:0]      res;
  } csn_burst_t;

endpackage

// File: src/c_source_normalizer_top.sv
// ----------------------------------------------------------------------------
// c_source_normalizer_top
// strips c comments, maps control bytes and squeezes whitespace
// ----------------------------------------------------------------------------
// the source beat is registered first; its burst then loads the result slots once they have room
// throughput: one source beat per cycle while the result slots have room; a byte with several results holds
//   the input until the single output port has drained the result slots
// reset: async active low, scanner returns to code mode with nothing pending
module c_source_normalizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_of_string_o
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                can_load;
  logic                fire;
  logic                accept;
  csn_pkg::csn_burst_t burst;
  csn_pkg::csn_res_t   head;

  assign fire       = in_valid_q && can_load;
  assign in_stall_o = in_valid_q && !can_load;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= in_byte_i;
  end

  csn_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .ch_i    (in_byte_q),
    .burst_o (burst)
  );

  csn_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .burst_i     (burst),
    .out_stall_i (out_stall_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .head_o      (head)
  );

  assign out_byte_o      = head.ch;
  assign has_byte_o      = head.has;
  assign end_of_string_o = head.eos;

endmodule

// File: src/csn_step.sv
// ----------------------------------------------------------------------------
// csn_step
// scanner state and per-byte logic: comment blanking, quoting, squeeze
// ----------------------------------------------------------------------------
module csn_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          ch_i,
  output csn_pkg::csn_burst_t burst_o
);

  typedef struct packed {
    logic       sp;
    logic       ts;
    logic [1:0] n;
    logic [7:0] c0;
    logic [7:0] c1;
  } csn_sq_t;

  function automatic logic is_white(logic [7:0] c);
    return (c == csn_pkg::CH_SPACE) || ((c >= csn_pkg::CH_TAB) && (c <= csn_pkg::CH_CR));
  endfunction

  // whitespace run collapse, leading runs dropped
  function automatic csn_sq_t squeeze(logic sp, logic ts, logic [7:0] c);
    csn_sq_t r;
    r    = '0;
    r.sp = sp;
    r.ts = ts;
    if (is_white(c)) begin
      if (ts) r.sp = 1'b1;
    end else if (sp) begin
      r.n  = 2'd2;
      r.c0 = csn_pkg::CH_SPACE;
      r.c1 = c;
      r.sp = 1'b0;
      r.ts = 1'b1;
    end else begin
      r.n  = 2'd1;
      r.c0 = c;
      r.ts = 1'b1;
    end
    return r;
  endfunction

  csn_pkg::csn_mode_e mode_q, mode_d;
  logic               slash_q, slash_d;
  logic               sp_q, sp_d;
  logic               ts_q, ts_d;

  logic               a_v, b_v, clear;
  logic [7:0]         a_ch, b_ch;
  logic [7:0]         cb_ch;
  logic               cb_slash;
  csn_pkg::csn_mode_e cb_mode;
  csn_sq_t            s1, s2;
  csn_pkg::csn_res_t [2:0] tmp;
  logic [1:0]         cnt;

  // what a code-mode byte turns into
  always_comb begin
    cb_slash = (ch_i == csn_pkg::CH_SLASH);
    if ((ch_i < csn_pkg::CH_SPACE) || (ch_i >= csn_pkg::CH_DEL)) cb_ch = csn_pkg::CH_SPACE;
    else cb_ch = ch_i;
    if (ch_i == csn_pkg::CH_SQUOTE) cb_mode = csn_pkg::MODE_SQ;
    else if (ch_i == csn_pkg::CH_DQUOTE) cb_mode = csn_pkg::MODE_DQ;
    else cb_mode = csn_pkg::MODE_CODE;
  end

  // scanner: picks up to two characters for the squeeze
  always_comb begin
    mode_d  = mode_q;
    slash_d = slash_q;
    a_v     = 1'b0;
    a_ch    = csn_pkg::CH_SPACE;
    b_v     = 1'b0;
    b_ch    = csn_pkg::CH_SPACE;
    clear   = 1'b0;
    if (ch_i == csn_pkg::CH_NUL) begin
      a_v   = slash_q;
      a_ch  = csn_pkg::CH_SLASH;
      clear = 1'b1;
    end else begin
      unique case (mode_q)
        csn_pkg::MODE_CODE: begin
          if (slash_q) begin
            slash_d = 1'b0;
            a_v     = 1'b1;
            if (ch_i == csn_pkg::CH_STAR) begin
              mode_d = csn_pkg::MODE_BLOCK;
            end else if (ch_i == csn_pkg::CH_SLASH) begin
              mode_d = csn_pkg::MODE_LINE;
            end else begin
              a_ch = csn_pkg::CH_SLASH;
              if (cb_slash) begin
                slash_d = 1'b1;
              end else begin
                b_v    = 1'b1;
                b_ch   = cb_ch;
                mode_d = cb_mode;
              end
            end
          end else if (cb_slash) begin
            slash_d = 1'b1;
          end else begin
            a_v    = 1'b1;
            a_ch   = cb_ch;
            mode_d = cb_mode;
          end
        end
        csn_pkg::MODE_BLOCK: begin
          a_v = 1'b1;
          if (ch_i == csn_pkg::CH_STAR) mode_d = csn_pkg::MODE_BLOCK_STAR;
        end
        csn_pkg::MODE_BLOCK_STAR: begin
          a_v = 1'b1;
          if (ch_i == csn_pkg::CH_SLASH) mode_d = csn_pkg::MODE_CODE;
          else if (ch_i != csn_pkg::CH_STAR) mode_d = csn_pkg::MODE_BLOCK;
        end
        csn_pkg::MODE_LINE: begin
          a_v = 1'b1;
          if (ch_i == csn_pkg::CH_LF) mode_d = csn_pkg::MODE_CODE;
        end
        csn_pkg::MODE_SQ: begin
          a_v  = 1'b1;
          a_ch = ch_i;
          if (ch_i == csn_pkg::CH_SQUOTE) mode_d = csn_pkg::MODE_CODE;
          else if (ch_i == csn_pkg::CH_BSLASH) mode_d = csn_pkg::MODE_SQ_ESC;
        end
        csn_pkg::MODE_SQ_ESC: begin
          a_v    = 1'b1;
          a_ch   = ch_i;
          mode_d = csn_pkg::MODE_SQ;
        end
        csn_pkg::MODE_DQ: begin
          a_v  = 1'b1;
          a_ch = ch_i;
          if (ch_i == csn_pkg::CH_DQUOTE) mode_d = csn_pkg::MODE_CODE;
          else if (ch_i == csn_pkg::CH_BSLASH) mode_d = csn_pkg::MODE_DQ_ESC;
        end
        csn_pkg::MODE_DQ_ESC: begin
          a_v    = 1'b1;
          a_ch   = ch_i;
          mode_d = csn_pkg::MODE_DQ;
        end
        default: begin
          mode_d = csn_pkg::MODE_CODE;
        end
      endcase
    end
  end

  // squeeze both characters in order and pack the results
  always_comb begin
    if (a_v) s1 = squeeze(sp_q, ts_q, a_ch);
    else s1 = '{sp: sp_q, ts: ts_q, n: 2'd0, c0: csn_pkg::CH_NUL, c1: csn_pkg::CH_NUL};
    if (b_v) s2 = squeeze(s1.sp, s1.ts, b_ch);
    else s2 = '{sp: s1.sp, ts: s1.ts, n: 2'd0, c0: csn_pkg::CH_NUL, c1: csn_pkg::CH_NUL};

    tmp = '0;
    cnt = 2'd0;
    if (s1.n != 2'd0) begin
      tmp[cnt] = '{ch: s1.c0, has: 1'b1, eos: 1'b0};
      cnt      = cnt + 2'd1;
    end
    if (s1.n == 2'd2) begin
      tmp[cnt] = '{ch: s1.c1, has: 1'b1, eos: 1'b0};
      cnt      = cnt + 2'd1;
    end
    if (s2.n != 2'd0) begin
      tmp[cnt] = '{ch: s2.c0, has: 1'b1, eos: 1'b0};
      cnt      = cnt + 2'd1;
    end
    if (s2.n == 2'd2) begin
      tmp[cnt] = '{ch: s2.c1, has: 1'b1, eos: 1'b0};
      cnt      = cnt + 2'd1;
    end

    // terminator: mark the last beat or emit a bare end marker
    if (clear) begin
      if (cnt == 2'd0) begin
        tmp[0] = '{ch: csn_pkg::CH_NUL, has: 1'b0, eos: 1'b1};
        cnt    = 2'd1;
      end else begin
        tmp[cnt - 2'd1].eos = 1'b1;
      end
    end

    burst_o.cnt = cnt;
    burst_o.res = tmp;

    sp_d = clear ? 1'b0 : s2.sp;
    ts_d = clear ? 1'b0 : s2.ts;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= csn_pkg::MODE_CODE;
      slash_q <= 1'b0;
      sp_q    <= 1'b0;
      ts_q    <= 1'b0;
    end else if (en_i) begin
      mode_q  <= clear ? csn_pkg::MODE_CODE : mode_d;
      slash_q <= clear ? 1'b0 : slash_d;
      sp_q    <= sp_d;
      ts_q    <= ts_d;
    end
  end

endmodule

// File: src/csn_outbuf.sv
// ----------------------------------------------------------------------------
// csn_outbuf
// three-slot result register, shifts one beat out per handshake
// ----------------------------------------------------------------------------
module csn_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  csn_pkg::csn_burst_t burst_i,
  input  logic                out_stall_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  output csn_pkg::csn_res_t   head_o
);

  csn_pkg::csn_res_t [2:0] slot_q, slot_d;
  logic [1:0]              cnt_q, cnt_d;
  logic                    pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // room for a new burst once the last waiting beat leaves
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = burst_i.res;
      cnt_d  = burst_i.cnt;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/csn_checker.sv
// ----------------------------------------------------------------------------
// csn_checker
// port-level checks on the normalized output stream
// ----------------------------------------------------------------------------
module csn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       end_of_string_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(has_byte_o) && $stable(end_of_string_o))
    else $error("result beat changed while stalled");

  // the input only backs up behind waiting result beats
  a_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a beat without a character is only the bare end marker
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> end_of_string_o && (out_byte_o == 8'h00))
    else $error("empty beat is not a clean end marker");

  // trailing spaces are dropped, so a string never ends on a space
  a_no_trail_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o && (out_byte_o == 8'h20) |-> !end_of_string_o)
    else $error("string ended on a space");

  // squeeze leaves only plain spaces, never nul or other whitespace
  a_no_raw_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> (out_byte_o != 8'h00)
      && ((out_byte_o < 8'h09) || (out_byte_o > 8'h0D)))
    else $error("unsqueezed whitespace or nul in output");

endmodule

bind c_source_normalizer_top csn_checker u_csn_checker (.*);
